### hdl/pit_pkg.sv
// Shared types and fixed field widths for the point-in-triangle block.
// No dependencies.
package pit_pkg;

  localparam int COORD_PORT_BITS   = 32;
  localparam int WEIGHT_FIELD_BITS = 17;

  // Control that travels alongside each item down the pipeline
  typedef struct packed {
    logic valid;
    logic in_tri;
    logic zero_sum;
  } pit_ctrl_t;

endpackage

### hdl/pit_front.sv
// Front end: translation, cross products, orientation signs and area sum.
// Five register stages. Depends on pit_pkg.
module pit_front #(
  parameter int C = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [pit_pkg::COORD_PORT_BITS-1:0] query_x,
  input  logic [pit_pkg::COORD_PORT_BITS-1:0] query_y,
  input  logic [pit_pkg::COORD_PORT_BITS-1:0] vert1_x,
  input  logic [pit_pkg::COORD_PORT_BITS-1:0] vert1_y,
  input  logic [pit_pkg::COORD_PORT_BITS-1:0] vert2_x,
  input  logic [pit_pkg::COORD_PORT_BITS-1:0] vert2_y,
  input  logic [pit_pkg::COORD_PORT_BITS-1:0] vert3_x,
  input  logic [pit_pkg::COORD_PORT_BITS-1:0] vert3_y,
  output pit_pkg::pit_ctrl_t                 ctrl,
  output logic [2*(C+1)+3-1:0]               den,
  output logic [2:0][2*(C+1)+1-1:0]          area_mag
);
  import pit_pkg::*;

  localparam int DW = C + 1;
  localparam int PW = 2 * DW;
  localparam int AW = PW + 1;
  localparam int SW = AW + 2;

  // tie-break code: {positive, negative}
  function automatic logic [1:0] tie_code(input logic signed [DW-1:0] x1,
                                          input logic signed [DW-1:0] y1,
                                          input logic signed [DW-1:0] x2,
                                          input logic signed [DW-1:0] y2);
    logic [1:0] r;
    if (y2 > y1)      r = 2'b10;
    else if (y2 < y1) r = 2'b01;
    else if (x1 > x2) r = 2'b10;
    else if (x1 < x2) r = 2'b01;
    else              r = 2'b00;
    return r;
  endfunction

  logic [4:0] vld;

  logic signed [DW-1:0] dx1, dy1, dx2, dy2, dx3, dy3;
  logic signed [PW-1:0] pa1, pa2, pb1, pb2, pc1, pc2;
  logic [1:0]           ta2, tb2, tc2, ta3, tb3, tc3;
  logic signed [AW-1:0] ar_a, ar_b, ar_c;
  logic signed [SW-1:0] sum;
  logic [AW-1:0]        mag_a, mag_b, mag_c;
  logic                 inside4;
  logic [AW-1:0]        mag5_a, mag5_b, mag5_c;
  logic                 inside5, zero5;
  logic [SW-1:0]        den5;

  logic pa, na, pb, nb, pc, nc;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  // stage 1: translate so the query point is the origin
  always_ff @(posedge clk) begin
    if (en) begin
      dx1 <= {vert1_x[C-1], vert1_x[C-1:0]} - {query_x[C-1], query_x[C-1:0]};
      dy1 <= {vert1_y[C-1], vert1_y[C-1:0]} - {query_y[C-1], query_y[C-1:0]};
      dx2 <= {vert2_x[C-1], vert2_x[C-1:0]} - {query_x[C-1], query_x[C-1:0]};
      dy2 <= {vert2_y[C-1], vert2_y[C-1:0]} - {query_y[C-1], query_y[C-1:0]};
      dx3 <= {vert3_x[C-1], vert3_x[C-1:0]} - {query_x[C-1], query_x[C-1:0]};
      dy3 <= {vert3_y[C-1], vert3_y[C-1:0]} - {query_y[C-1], query_y[C-1:0]};
    end
  end

  // stage 2: cross-product terms and tie-break codes
  always_ff @(posedge clk) begin
    if (en) begin
      pa1 <= dy2 * dx3;
      pa2 <= dx2 * dy3;
      pb1 <= dy3 * dx1;
      pb2 <= dx3 * dy1;
      pc1 <= dy1 * dx2;
      pc2 <= dx1 * dy2;
      ta2 <= tie_code(dx2, dy2, dx3, dy3);
      tb2 <= tie_code(dx3, dy3, dx1, dy1);
      tc2 <= tie_code(dx1, dy1, dx2, dy2);
    end
  end

  // stage 3: twice-signed areas
  always_ff @(posedge clk) begin
    if (en) begin
      ar_a <= AW'(pa1) - AW'(pa2);
      ar_b <= AW'(pb1) - AW'(pb2);
      ar_c <= AW'(pc1) - AW'(pc2);
      ta3  <= ta2;
      tb3  <= tb2;
      tc3  <= tc2;
    end
  end

  // orientation signs, zero areas fall back to the tie-break
  always_comb begin
    pa = (ar_a != '0) ? !ar_a[AW-1] : ta3[1];
    na = (ar_a != '0) ?  ar_a[AW-1] : ta3[0];
    pb = (ar_b != '0) ? !ar_b[AW-1] : tb3[1];
    nb = (ar_b != '0) ?  ar_b[AW-1] : tb3[0];
    pc = (ar_c != '0) ? !ar_c[AW-1] : tc3[1];
    nc = (ar_c != '0) ?  ar_c[AW-1] : tc3[0];
  end

  // stage 4: inside test, signed sum, magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      inside4 <= (pa | na) && (pa == pb) && (na == nb) && (pa == pc) && (na == nc);
      sum     <= SW'(ar_a) + SW'(ar_b) + SW'(ar_c);
      mag_a   <= ar_a[AW-1] ? AW'(-ar_a) : AW'(ar_a);
      mag_b   <= ar_b[AW-1] ? AW'(-ar_b) : AW'(ar_b);
      mag_c   <= ar_c[AW-1] ? AW'(-ar_c) : AW'(ar_c);
    end
  end

  // stage 5: divisor magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      inside5 <= inside4;
      zero5   <= (sum == '0);
      den5    <= sum[SW-1] ? SW'(-sum) : SW'(sum);
      mag5_a  <= mag_a;
      mag5_b  <= mag_b;
      mag5_c  <= mag_c;
    end
  end

  assign ctrl.valid    = vld[4];
  assign ctrl.in_tri   = inside5;
  assign ctrl.zero_sum = zero5;
  assign den           = den5;
  assign area_mag      = {mag5_c, mag5_b, mag5_a};

endmodule

### hdl/pit_div_step.sv
// One restoring-division step for the three weights, one quotient bit each.
// Depends on pit_pkg.
module pit_div_step #(
  parameter int SW    = 69,
  parameter int QW    = 17,
  parameter bit SHIFT = 1'b1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  pit_pkg::pit_ctrl_t      ctrl_i,
  input  logic [SW-1:0]           den_i,
  input  logic [2:0][SW:0]        rem_i,
  input  logic [2:0][QW-1:0]      quo_i,
  output pit_pkg::pit_ctrl_t      ctrl_o,
  output logic [SW-1:0]           den_o,
  output logic [2:0][SW:0]        rem_o,
  output logic [2:0][QW-1:0]      quo_o
);
  import pit_pkg::*;

  logic [2:0][SW:0] trial;
  logic [2:0]       ge;

  // trial remainder and compare per lane
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      trial[k] = SHIFT ? {rem_i[k][SW-1:0], 1'b0} : rem_i[k];
      ge[k]    = trial[k] >= {1'b0, den_i};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_o.valid <= 1'b0;
    end else if (en) begin
      ctrl_o.valid <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_o.in_tri   <= ctrl_i.in_tri;
      ctrl_o.zero_sum <= ctrl_i.zero_sum;
      den_o           <= den_i;
      for (int k = 0; k < 3; k++) begin
        rem_o[k] <= ge[k] ? trial[k] - {1'b0, den_i} : trial[k];
        quo_o[k] <= {quo_i[k][QW-2:0], ge[k]};
      end
    end
  end

endmodule

### hdl/point_in_triangle_barycentric.sv
// Point-in-triangle test with barycentric weights: top level.
// Depends on pit_pkg, pit_front and pit_div_step.
//
// Takes a query point and three vertices (signed fixed point, low COORD_BITS
// bits of each port used) and reports whether the point lies inside the
// triangle under a simulation-of-simplicity tie-break, with the three
// barycentric weights as unsigned Q1.WEIGHT_FRAC_BITS truncated toward zero
// (zero when outside or when the area sum is zero). Fully pipelined: one
// transfer per cycle in each direction while the output is not held, through
// five front-end stages (translate, multiply, area, sum, divisor) and one
// restoring-division stage per quotient bit. The whole pipeline holds while
// a result waits to be taken; no reset-time sweep.
module point_in_triangle_barycentric #(
  parameter int COORD_BITS       = 32,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [pit_pkg::COORD_PORT_BITS-1:0]  query_x,
  input  logic [pit_pkg::COORD_PORT_BITS-1:0]  query_y,
  input  logic [pit_pkg::COORD_PORT_BITS-1:0]  vert1_x,
  input  logic [pit_pkg::COORD_PORT_BITS-1:0]  vert1_y,
  input  logic [pit_pkg::COORD_PORT_BITS-1:0]  vert2_x,
  input  logic [pit_pkg::COORD_PORT_BITS-1:0]  vert2_y,
  input  logic [pit_pkg::COORD_PORT_BITS-1:0]  vert3_x,
  input  logic [pit_pkg::COORD_PORT_BITS-1:0]  vert3_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 inside_res,
  output logic [pit_pkg::WEIGHT_FIELD_BITS-1:0] weight_a,
  output logic [pit_pkg::WEIGHT_FIELD_BITS-1:0] weight_b,
  output logic [pit_pkg::WEIGHT_FIELD_BITS-1:0] weight_c
);
  import pit_pkg::*;

  localparam int AW = 2 * (COORD_BITS + 1) + 1;
  localparam int SW = AW + 2;
  localparam int QW = WEIGHT_FRAC_BITS + 1;

  logic en;

  pit_ctrl_t                   ctrl_c [QW+1];
  logic [SW-1:0]               den_c  [QW+1];
  logic [2:0][SW:0]            rem_c  [QW+1];
  logic [2:0][QW-1:0]          quo_c  [QW+1];
  logic [2:0][AW-1:0]          mag;
  logic                        keep;

  // global advance: move whenever the output slot is free or being taken
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  pit_front #(.C(COORD_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .query_x  (query_x),
    .query_y  (query_y),
    .vert1_x  (vert1_x),
    .vert1_y  (vert1_y),
    .vert2_x  (vert2_x),
    .vert2_y  (vert2_y),
    .vert3_x  (vert3_x),
    .vert3_y  (vert3_y),
    .ctrl     (ctrl_c[0]),
    .den      (den_c[0]),
    .area_mag (mag)
  );

  // division starts from the area magnitude itself
  for (genvar k = 0; k < 3; k++) begin : g_seed
    assign rem_c[0][k] = (SW + 1)'(mag[k]);
    assign quo_c[0][k] = '0;
  end

  // one quotient bit per stage, integer bit first
  for (genvar s = 0; s < QW; s++) begin : g_div
    pit_div_step #(
      .SW    (SW),
      .QW    (QW),
      .SHIFT (s != 0)
    ) u_step (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .ctrl_i (ctrl_c[s]),
      .den_i  (den_c[s]),
      .rem_i  (rem_c[s]),
      .quo_i  (quo_c[s]),
      .ctrl_o (ctrl_c[s+1]),
      .den_o  (den_c[s+1]),
      .rem_o  (rem_c[s+1]),
      .quo_o  (quo_c[s+1])
    );
  end

  // result formatting off the last stage register
  assign keep       = ctrl_c[QW].in_tri && !ctrl_c[QW].zero_sum;
  assign out_valid  = ctrl_c[QW].valid;
  assign inside_res = ctrl_c[QW].in_tri;
  assign weight_a   = keep ? WEIGHT_FIELD_BITS'(quo_c[QW][0]) : '0;
  assign weight_b   = keep ? WEIGHT_FIELD_BITS'(quo_c[QW][1]) : '0;
  assign weight_c   = keep ? WEIGHT_FIELD_BITS'(quo_c[QW][2]) : '0;

`ifndef SYNTHESIS
  // an outside point never carries weights
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !inside_res |-> weight_a == '0 && weight_b == '0 && weight_c == '0)
    else $error("weights nonzero for an outside point");

  // weights of an inside point never sum above one
  a_weight_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && inside_res && (WEIGHT_FRAC_BITS < WEIGHT_FIELD_BITS) |->
      (19'(weight_a) + 19'(weight_b) + 19'(weight_c)) <= (19'(1) << WEIGHT_FRAC_BITS))
    else $error("weights sum above one");

  // a held result keeps the pipeline frozen
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(ctrl_c[0]) && $stable(quo_c[QW]))
    else $error("pipeline moved during stall");
`endif

endmodule
